[sv/baro_temp_pressure_compensation_assert.svh]
// assertion macros for the barometric compensation block
// no dependencies; included by modules that carry assertions
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH

`ifndef SYNTHESIS
`define BTPC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("btpc assertion failed");
`define BTPC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("btpc assertion failed");
`else
`define BTPC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BTPC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[sv/btpc_pkg.sv]
// shared types and constants for the barometric compensation pipeline
// no dependencies
`default_nettype none
package btpc_pkg;

  localparam int DIV_STEPS = 64;

  typedef enum logic [1:0] {
    CFG_TEMP,
    CFG_PRESS_A,
    CFG_PRESS_B,
    CFG_PRESS_C
  } cfg_idx_t;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic signed [31:0] fine_temperature;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
  } out_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } coef_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic signed [31:0] fine_temperature;
  } tinfo_t;

  // one step of the restoring divider: numq holds numerator bits on top,
  // quotient bits shift in at the bottom
  typedef struct packed {
    logic [30:0] rem;
    logic [63:0] numq;
    logic [30:0] md;
    logic        neg;
    logic        zero;
    tinfo_t      tinfo;
  } div_stage_t;

endpackage
`default_nettype wire

[sv/btpc_temp.sv]
// temperature compensation stages: fine temperature, centi-degrees, offset for pressure
// depends on btpc_pkg
`default_nettype none
module btpc_temp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               in_valid,
  input  wire btpc_pkg::in_t      in_data,
  input  wire btpc_pkg::coef_t    coef,
  output logic                    out_valid,
  output btpc_pkg::tinfo_t        out_tinfo,
  output logic signed [25:0]      out_v1,
  output logic [19:0]             out_adc_p
);

  logic [4:0]          vld_r;
  logic [19:0]         adcp_r [5];
  logic signed [18:0]  a_nxt, a_r;
  logic signed [17:0]  b_nxt, b_r;
  logic signed [34:0]  m1_nxt, m1_r;
  logic signed [35:0]  bb_nxt, bb_r;
  logic signed [23:0]  tv1_nxt, tv1_r;
  logic signed [37:0]  m2_nxt, m2_r;
  logic signed [24:0]  tf_nxt, tf_r, tf5_r;
  logic signed [27:0]  t5;
  logic signed [19:0]  temp_nxt, temp_r;
  logic signed [25:0]  v1_nxt, v1_r;

  always_comb begin
    a_nxt    = $signed({2'b00, in_data.raw_temperature[19:3]}) - $signed({2'b00, coef.t1, 1'b0});
    b_nxt    = $signed({2'b00, in_data.raw_temperature[19:4]}) - $signed({2'b00, coef.t1});
    m1_nxt   = a_r * coef.t2;
    bb_nxt   = b_r * b_r;
    tv1_nxt  = m1_r[34:11];
    // square is never negative, below 2^32
    m2_nxt   = $signed({1'b0, bb_r[32:12]}) * coef.t3;
    tf_nxt   = tv1_r + $signed(m2_r[37:14]);
    t5       = (tf_r <<< 2) + tf_r + 28'sd128;
    temp_nxt = t5[27:8];
    v1_nxt   = tf_r - 26'sd128000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      m1_r   <= m1_nxt;
      bb_r   <= bb_nxt;
      tv1_r  <= tv1_nxt;
      m2_r   <= m2_nxt;
      tf_r   <= tf_nxt;
      temp_r <= temp_nxt;
      tf5_r  <= tf_r;
      v1_r   <= v1_nxt;
      adcp_r[0] <= in_data.raw_pressure;
      for (int i = 1; i < 5; i++) begin
        adcp_r[i] <= adcp_r[i-1];
      end
    end
  end

  assign out_valid                   = vld_r[4];
  assign out_tinfo.temperature_centi = {{12{temp_r[19]}}, temp_r};
  assign out_tinfo.fine_temperature  = {{7{tf5_r[24]}}, tf5_r};
  assign out_v1                      = v1_r;
  assign out_adc_p                   = adcp_r[4];

endmodule
`default_nettype wire

[sv/btpc_pre.sv]
// pressure front stages: offset terms, divisor and scaled numerator, magnitudes
// depends on btpc_pkg
`default_nettype none
module btpc_pre (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic                  in_valid,
  input  wire btpc_pkg::tinfo_t      in_tinfo,
  input  wire logic signed [25:0]    in_v1,
  input  wire logic [19:0]           in_adc_p,
  input  wire btpc_pkg::coef_t       coef,
  output logic                       out_valid,
  output btpc_pkg::div_stage_t       out_st
);

  logic [6:0]             vld_r;
  btpc_pkg::tinfo_t       ti_r [7];
  logic signed [51:0]     sq_nxt, sq_r;
  logic signed [41:0]     m5_nxt, m5_r, m5b_r;
  logic signed [41:0]     m2p_nxt, m2p_r, m2pb_r;
  logic [20:0]            pp_nxt, pp_r, ppb_r, ppc_r;
  logic signed [62:0]     x6_nxt, x6_r, x3_nxt, x3_r;
  logic signed [63:0]     v2_nxt, v2_r, u_nxt;
  logic signed [55:0]     u_r;
  logic [43:0]            pl_nxt, pl_r;
  logic signed [44:0]     ph_nxt, ph_r;
  logic signed [63:0]     phx;
  logic [63:0]            x_nxt, x_r, prod;
  logic signed [30:0]     d_nxt, d_r, db_r;
  logic [43:0]            nl_nxt, nl_r;
  logic [31:0]            nh_nxt, nh_r;
  logic [63:0]            n_nxt, n_r;
  logic                   zero_nxt, zero_r, neg_nxt, neg_r;
  logic [63:0]            mn_nxt, mn_r;
  logic [30:0]            md_nxt, md_r;
  logic                   zero2_r, neg2_r;

  always_comb begin
    sq_nxt  = in_v1 * in_v1;
    m5_nxt  = in_v1 * coef.p5;
    m2p_nxt = in_v1 * coef.p2;
    pp_nxt  = 21'd1048576 - {1'b0, in_adc_p};
    // square below 2^46
    x6_nxt  = $signed({1'b0, sq_r[45:0]}) * coef.p6;
    x3_nxt  = $signed({1'b0, sq_r[45:0]}) * coef.p3;
    v2_nxt  = x6_r + (m5b_r <<< 17) + (coef.p4 <<< 35);
    u_nxt   = (x3_r >>> 8) + (m2pb_r <<< 12) + 64'sd140737488355328;
    pl_nxt  = u_r[27:0] * coef.p1;
    ph_nxt  = $signed(u_r[55:28]) * $signed({1'b0, coef.p1});
    x_nxt   = {12'd0, ppc_r, 31'd0} - v2_r;
    phx     = ph_r;
    prod    = {20'd0, pl_r} + {phx[35:0], 28'd0};
    d_nxt   = prod[63:33];
    nl_nxt  = x_r[31:0] * 12'd3125;
    nh_nxt  = x_r[63:32] * 32'd3125;
    n_nxt   = {20'd0, nl_r} + {nh_r, 32'd0};
    zero_nxt = (db_r == 31'sd0);
    neg_nxt  = n_nxt[63] ^ db_r[30];
    mn_nxt  = n_r[63] ? (64'd0 - n_r) : n_r;
    md_nxt  = d_r[30] ? (31'd0 - d_r) : d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      sq_r  <= sq_nxt;
      m5_r  <= m5_nxt;
      m2p_r <= m2p_nxt;
      pp_r  <= pp_nxt;
      // stage 2
      x6_r   <= x6_nxt;
      x3_r   <= x3_nxt;
      m5b_r  <= m5_r;
      m2pb_r <= m2p_r;
      ppb_r  <= pp_r;
      // stage 3
      v2_r  <= v2_nxt;
      u_r   <= u_nxt[55:0];
      ppc_r <= ppb_r;
      // stage 4
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
      x_r  <= x_nxt;
      // stage 5
      db_r <= d_nxt;
      nl_r <= nl_nxt;
      nh_r <= nh_nxt;
      // stage 6
      n_r    <= n_nxt;
      d_r    <= db_r;
      zero_r <= zero_nxt;
      neg_r  <= neg_nxt;
      // stage 7
      mn_r    <= mn_nxt;
      md_r    <= md_nxt;
      zero2_r <= zero_r;
      neg2_r  <= neg_r;
      ti_r[0] <= in_tinfo;
      for (int i = 1; i < 7; i++) begin
        ti_r[i] <= ti_r[i-1];
      end
    end
  end

  assign out_valid   = vld_r[6];
  assign out_st.rem  = '0;
  assign out_st.numq = mn_r;
  assign out_st.md   = md_r;
  assign out_st.neg  = neg2_r;
  assign out_st.zero = zero2_r;
  assign out_st.tinfo = ti_r[6];

endmodule
`default_nettype wire

[sv/btpc_div.sv]
// pipelined restoring divider, one quotient bit per stage, unsigned magnitudes
// depends on btpc_pkg
`default_nettype none
module btpc_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic                  in_valid,
  input  wire btpc_pkg::div_stage_t  in_st,
  output logic                       out_valid,
  output btpc_pkg::div_stage_t       out_st
);

  localparam int Steps = btpc_pkg::DIV_STEPS;

  logic [Steps-1:0]      vld_r;
  btpc_pkg::div_stage_t  st_r [Steps];

  function automatic btpc_pkg::div_stage_t div_step(input btpc_pkg::div_stage_t s);
    btpc_pkg::div_stage_t r;
    logic [31:0] trial;
    logic [31:0] diff;
    logic        ge;
    trial  = {s.rem, s.numq[63]};
    diff   = trial - {1'b0, s.md};
    ge     = (trial >= {1'b0, s.md});
    r      = s;
    r.rem  = ge ? diff[30:0] : trial[30:0];
    r.numq = {s.numq[62:0], ge};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Steps-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= div_step(in_st);
      for (int i = 1; i < Steps; i++) begin
        st_r[i] <= div_step(st_r[i-1]);
      end
    end
  end

  assign out_valid = vld_r[Steps-1];
  assign out_st    = st_r[Steps-1];

endmodule
`default_nettype wire

[sv/btpc_post.sv]
// pressure back stages: quotient sign, second-order corrections, Q24.8 result
// depends on btpc_pkg
`default_nettype none
module btpc_post (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic                  in_valid,
  input  wire btpc_pkg::div_stage_t  in_st,
  input  wire btpc_pkg::coef_t       coef,
  output logic                       out_valid,
  output btpc_pkg::out_t             out_data
);

  logic [5:0]             vld_r;
  logic [5:0]             zero_r;
  btpc_pkg::tinfo_t       ti_r [6];
  logic [63:0]            p_nxt, pa_r, pb_r, pc_r, pd_r, pe_r;
  logic signed [63:0]     qv;
  logic [31:0]            ql, qh, p8x, p9x;
  logic [63:0]            ll_nxt, ll_r;
  logic [31:0]            lh_nxt, lh_r;
  logic signed [48:0]     pl8_nxt, pl8_r;
  logic [31:0]            ph8_nxt, ph8_r;
  logic signed [63:0]     pl8x, c2full;
  logic signed [63:0]     c2_nxt, c2_r, c2d_r, c2e_r;
  logic [63:0]            sq_nxt, sq_r;
  logic signed [48:0]     s9l_nxt, s9l_r;
  logic [31:0]            s9h_nxt, s9h_r;
  logic signed [63:0]     s9lx, c1full, c1_nxt, c1_r;
  logic [63:0]            s_nxt, s_r;
  logic [31:0]            res;

  always_comb begin
    p_nxt   = in_st.neg ? (64'd0 - in_st.numq) : in_st.numq;
    qv      = $signed(pa_r) >>> 13;
    ql      = qv[31:0];
    qh      = qv[63:32];
    p8x     = {{16{coef.p8[15]}}, coef.p8};
    p9x     = {{16{coef.p9[15]}}, coef.p9};
    // square mod 2^64 from 32-bit halves
    ll_nxt  = ql * ql;
    lh_nxt  = ql * qh;
    pl8_nxt = $signed({1'b0, pa_r[31:0]}) * coef.p8;
    ph8_nxt = pa_r[63:32] * p8x;
    sq_nxt  = ll_r + {lh_r[30:0], 33'd0};
    pl8x    = pl8_r;
    c2full  = pl8x + $signed({ph8_r, 32'd0});
    c2_nxt  = c2full >>> 19;
    s9l_nxt = $signed({1'b0, sq_r[31:0]}) * coef.p9;
    s9h_nxt = sq_r[63:32] * p9x;
    s9lx    = s9l_r;
    c1full  = s9lx + $signed({s9h_r, 32'd0});
    c1_nxt  = c1full >>> 25;
    s_nxt   = pe_r + c1_r + c2e_r;
    res     = s_r[39:8] + {{12{coef.p7[15]}}, coef.p7, 4'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r  <= p_nxt;
      ll_r  <= ll_nxt;
      lh_r  <= lh_nxt;
      pl8_r <= pl8_nxt;
      ph8_r <= ph8_nxt;
      pb_r  <= pa_r;
      sq_r  <= sq_nxt;
      c2_r  <= c2_nxt;
      pc_r  <= pb_r;
      s9l_r <= s9l_nxt;
      s9h_r <= s9h_nxt;
      c2d_r <= c2_r;
      pd_r  <= pc_r;
      c1_r  <= c1_nxt;
      c2e_r <= c2d_r;
      pe_r  <= pd_r;
      s_r   <= s_nxt;
      zero_r  <= {zero_r[4:0], in_st.zero};
      ti_r[0] <= in_st.tinfo;
      for (int i = 1; i < 6; i++) begin
        ti_r[i] <= ti_r[i-1];
      end
    end
  end

  assign out_valid                  = vld_r[5];
  assign out_data.temperature_centi = ti_r[5].temperature_centi;
  assign out_data.fine_temperature  = ti_r[5].fine_temperature;
  assign out_data.pressure_q24_8    = zero_r[5] ? 32'd0 : res;
  assign out_data.pressure_valid    = !zero_r[5];

endmodule
`default_nettype wire

[sv/baro_temp_pressure_compensation.sv]
// Barometric temperature and pressure compensation, 64-bit integer scheme.
// One raw temperature/pressure pair enters per clock and one result leaves per
// clock while the pipeline is not frozen; an item passes 5 temperature stages,
// 7 pressure front stages, 64 divider stages, 6 back stages and the output
// register, of which the one-bit-per-stage 64-bit divider is the longest part.
// The whole pipeline freezes only while the output register holds a result
// that the sink stalls. The user must write calibration words through the cfg
// port only while no item is in flight (not enforced); cfg_ready is always high.
`default_nettype none
`include "baro_temp_pressure_compensation_assert.svh"
module baro_temp_pressure_compensation (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire btpc_pkg::in_t       in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output btpc_pkg::out_t           out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire btpc_pkg::cfg_idx_t  cfg_index,
  input  wire logic [47:0]         cfg_data
);

  logic [47:0]           temp_coeffs_r, press_a_r, press_b_r, press_c_r;
  btpc_pkg::coef_t       coef;
  logic                  adv;
  logic                  t_valid, pre_valid, div_valid, post_valid;
  btpc_pkg::tinfo_t      t_tinfo;
  logic signed [25:0]    t_v1;
  logic [19:0]           t_adc_p;
  btpc_pkg::div_stage_t  pre_st, div_st;
  btpc_pkg::out_t        post_data;
  logic                  out_valid_r;
  btpc_pkg::out_t        out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_a_r     <= '0;
      press_b_r     <= '0;
      press_c_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        btpc_pkg::CFG_TEMP:    temp_coeffs_r <= cfg_data;
        btpc_pkg::CFG_PRESS_A: press_a_r     <= cfg_data;
        btpc_pkg::CFG_PRESS_B: press_b_r     <= cfg_data;
        btpc_pkg::CFG_PRESS_C: press_c_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign coef.t1 = temp_coeffs_r[15:0];
  assign coef.t2 = temp_coeffs_r[31:16];
  assign coef.t3 = temp_coeffs_r[47:32];
  assign coef.p1 = press_a_r[15:0];
  assign coef.p2 = press_a_r[31:16];
  assign coef.p3 = press_a_r[47:32];
  assign coef.p4 = press_b_r[15:0];
  assign coef.p5 = press_b_r[31:16];
  assign coef.p6 = press_b_r[47:32];
  assign coef.p7 = press_c_r[15:0];
  assign coef.p8 = press_c_r[31:16];
  assign coef.p9 = press_c_r[47:32];

  // everything moves unless a finished result is waiting on a stalled sink
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  btpc_temp u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .coef      (coef),
    .out_valid (t_valid),
    .out_tinfo (t_tinfo),
    .out_v1    (t_v1),
    .out_adc_p (t_adc_p)
  );

  btpc_pre u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (t_valid),
    .in_tinfo  (t_tinfo),
    .in_v1     (t_v1),
    .in_adc_p  (t_adc_p),
    .coef      (coef),
    .out_valid (pre_valid),
    .out_st    (pre_st)
  );

  btpc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (pre_valid),
    .in_st     (pre_st),
    .out_valid (div_valid),
    .out_st    (div_st)
  );

  btpc_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (div_valid),
    .in_st     (div_st),
    .coef      (coef),
    .out_valid (post_valid),
    .out_data  (post_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= post_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= post_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BTPC_ASSERT_IMP(a_zero_divisor, clk, rst_n, out_valid_r && !out_data_r.pressure_valid, out_data_r.pressure_q24_8 == 32'd0)
  `BTPC_ASSERT_IMP(a_fine_range, clk, rst_n, out_valid_r, (out_data_r.fine_temperature[31:23] == 9'd0) || (out_data_r.fine_temperature[31:23] == 9'h1ff))
  `BTPC_ASSERT_NXT(a_result_lands, clk, rst_n, post_valid && adv, out_valid_r)

endmodule
`default_nettype wire
